@@ rtl/fpws_pkg.sv @@
// Package for the flash page write splitter.
// Holds field widths, page geometry and the controller/datapath interface types.
// No dependencies.
package fpws_pkg;

	localparam int ADDR_W    = 24;
	localparam int COUNT_W   = 14;
	localparam int LEN_W     = 9;
	localparam int PAGE_SIZE = 256;
	localparam int MAX_BYTES = 8192;
	localparam int PAGE_BITS = $clog2(PAGE_SIZE);
	localparam int ROOM_W    = PAGE_BITS + 1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic final_chunk;
	} stat_t;

endpackage

@@ rtl/fpws_dp.sv @@
// Datapath of the flash page write splitter: address and remaining-count
// registers, page room and chunk length, chunk output registers.
// Depends on fpws_pkg.
module fpws_dp (
	input  logic                          clk,
	input  logic [fpws_pkg::ADDR_W-1:0]   start_address,
	input  logic [fpws_pkg::COUNT_W-1:0]  byte_count,
	input  fpws_pkg::cmd_t                cmd,
	output fpws_pkg::stat_t               stat,
	output logic [fpws_pkg::ADDR_W-1:0]   chunk_address,
	output logic [fpws_pkg::LEN_W-1:0]    chunk_length,
	output logic                          last_chunk
);

	localparam logic [fpws_pkg::COUNT_W-1:0] MaxCount = fpws_pkg::COUNT_W'(fpws_pkg::MAX_BYTES);
	localparam logic [fpws_pkg::ROOM_W-1:0]  PageRoom = fpws_pkg::ROOM_W'(fpws_pkg::PAGE_SIZE);

	logic [fpws_pkg::ADDR_W-1:0]  addr_q;
	logic [fpws_pkg::COUNT_W-1:0] rem_q;
	logic [fpws_pkg::COUNT_W-1:0] count_sat;
	logic [fpws_pkg::ROOM_W-1:0]  room;
	logic [fpws_pkg::COUNT_W-1:0] room_ext;
	logic [fpws_pkg::COUNT_W-1:0] len_full;
	logic [fpws_pkg::LEN_W-1:0]   len;
	logic [fpws_pkg::ADDR_W-1:0]  chunk_address_q;
	logic [fpws_pkg::LEN_W-1:0]   chunk_length_q;
	logic                         last_q;

	always_comb begin
		count_sat = (byte_count > MaxCount) ? MaxCount : byte_count;
		room      = PageRoom - {1'b0, addr_q[fpws_pkg::PAGE_BITS-1:0]};
		room_ext  = fpws_pkg::COUNT_W'(room);
		len_full  = (rem_q < room_ext) ? rem_q : room_ext;
		len       = fpws_pkg::LEN_W'(len_full);
		stat.count_zero  = (byte_count == '0);
		stat.final_chunk = (rem_q <= room_ext);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= start_address;
			rem_q  <= count_sat;
		end else if (cmd.step) begin
			addr_q <= addr_q + fpws_pkg::ADDR_W'(len);
			rem_q  <= rem_q - len_full;
		end
		if (cmd.step) begin
			chunk_address_q <= addr_q;
			chunk_length_q  <= len;
			last_q          <= stat.final_chunk;
		end
	end

	assign chunk_address = chunk_address_q;
	assign chunk_length  = chunk_length_q;
	assign last_chunk    = last_q;

endmodule

@@ rtl/fpws_ctrl.sv @@
// Controller of the flash page write splitter: request acceptance,
// chunk sequencing and the output valid register.
// Depends on fpws_pkg.
module fpws_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	output logic             chunk_valid,
	input  logic             chunk_ready,
	input  fpws_pkg::stat_t  stat,
	output fpws_pkg::cmd_t   cmd
);

	fpws_pkg::state_t state_q;
	logic             out_valid_q;

	always_comb begin
		req_ready = (state_q == fpws_pkg::ST_IDLE);
		cmd.load  = req_ready && req_valid;
		cmd.step  = (state_q == fpws_pkg::ST_RUN) && (!out_valid_q || chunk_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fpws_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				fpws_pkg::ST_IDLE: begin
					if (cmd.load && !stat.count_zero) begin
						state_q <= fpws_pkg::ST_RUN;
					end
				end
				fpws_pkg::ST_RUN: begin
					if (cmd.step && stat.final_chunk) begin
						state_q <= fpws_pkg::ST_IDLE;
					end
				end
				default: state_q <= fpws_pkg::ST_IDLE;
			endcase
			if (cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (chunk_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign chunk_valid = out_valid_q;

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && !stat.count_zero |=> state_q == fpws_pkg::ST_RUN)
		else $error("nonzero request did not start chunking");

	a_final_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && stat.final_chunk |=> state_q == fpws_pkg::ST_IDLE && out_valid_q)
		else $error("final chunk did not return to idle with a chunk pending");

	a_step_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> state_q == fpws_pkg::ST_RUN && !cmd.load)
		else $error("step issued outside of chunking");

	a_run_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fpws_pkg::ST_RUN && !cmd.step |=> state_q == fpws_pkg::ST_RUN && out_valid_q)
		else $error("chunking stopped without a final chunk");

endmodule

@@ rtl/flash_page_write_splitter_core.sv @@
// Top level of the flash page write splitter: joins controller and datapath.
// Depends on fpws_pkg, fpws_ctrl, fpws_dp.
//
//   channel   handshake                  payload
//   request   req_valid / req_ready      start_address, byte_count
//   chunk     chunk_valid / chunk_ready  chunk_address, chunk_length, last_chunk
//
// A request is loaded, then one chunk per cycle unless a chunk stalls, set by the
// single address/remaining-count update loop: up to 33 chunks for 8192 bytes.
// A zero byte count is consumed and produces no chunk.
// The next request is taken once the final chunk sits in the output register.
// A stalled chunk holds the sequencer; reset clears state and the output valid.
module flash_page_write_splitter_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [fpws_pkg::ADDR_W-1:0]   start_address,
	input  logic [fpws_pkg::COUNT_W-1:0]  byte_count,
	output logic                          chunk_valid,
	input  logic                          chunk_ready,
	output logic [fpws_pkg::ADDR_W-1:0]   chunk_address,
	output logic [fpws_pkg::LEN_W-1:0]    chunk_length,
	output logic                          last_chunk
);

	fpws_pkg::cmd_t  cmd;
	fpws_pkg::stat_t stat;

	fpws_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.chunk_valid (chunk_valid),
		.chunk_ready (chunk_ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	fpws_dp u_dp (
		.clk           (clk),
		.start_address (start_address),
		.byte_count    (byte_count),
		.cmd           (cmd),
		.stat          (stat),
		.chunk_address (chunk_address),
		.chunk_length  (chunk_length),
		.last_chunk    (last_chunk)
	);

endmodule
